// ===== sv/muta_pkg.sv =====
// Package: shared types, constants and codes for media usage time accounting.
package muta_pkg;
    localparam int TableEntries = 16;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam logic [31:0] IgnoredReset = 32'd1013;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_MIX_IGN = 3'd1;
    localparam logic [2:0] ST_CALLER  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic [2:0] ST_REMOVED = 3'd5;

    localparam int DevSpk  = 0;
    localparam int DevOth  = 1;
    localparam int DevBoth = 2;

    typedef struct packed {
        logic load;     // latch request
        logic scan;     // step scan index
        logic update;   // apply event at scan result
        logic done;     // drive result strobe
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic is_table;
    } t_stat;
endpackage

// ===== sv/muta_ctrl.sv =====
// Controller: sequences latch, table scan, update and result.
module muta_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  muta_pkg::t_stat  i_stat,
    output muta_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.is_table) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.scan_last) n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== sv/muta_dp.sv =====
// Datapath: device timers, mixer count, caller table and result registers.
module muta_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  muta_pkg::t_cmd      i_cmd,
    output muta_pkg::t_stat     o_stat,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic [6:0]          i_event_flags,
    input  logic signed [31:0]  i_time_ms,
    input  logic [31:0]         i_caller_id,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_caller_audio_total,
    output logic signed [31:0]  o_caller_video_total,
    output logic signed [7:0]   o_caller_refs,
    output logic signed [31:0]  o_speaker_total,
    output logic signed [31:0]  o_other_total,
    output logic signed [31:0]  o_both_total,
    output logic [15:0]         o_mixer_refs
);
    localparam int N = muta_pkg::TableEntries;
    localparam int W = muta_pkg::IdxW;

    logic [31:0] r_ign;
    logic [6:0]  r_flags;
    logic [31:0] r_t, r_caller;
    logic [2:0]  r_on;
    logic [31:0] r_dlast [3];
    logic [31:0] r_dtot  [3];
    logic [15:0] r_mix;

    logic [N-1:0] r_valid;
    logic [31:0] r_ecaller [N];
    logic [31:0] r_alast [N];
    logic [31:0] r_vlast [N];
    logic [31:0] r_atot [N];
    logic [31:0] r_vtot [N];
    logic [7:0]  r_cnt [N];

    logic [W:0]   r_idx;
    logic         r_hit, r_free_ok;
    logic [W-1:0] r_hit_idx, r_free_idx;
    logic [2:0]   r_status;
    logic [31:0]  r_oa, r_ov;
    logic [7:0]   r_oc;

    logic is_route, is_mstart, is_mstop, is_ign;
    logic [W-1:0] cur;

    assign is_route  = |r_flags[6:5];
    assign is_mstart = !is_route && r_flags[3];
    assign is_mstop  = !is_route && !r_flags[3] && r_flags[4];
    assign is_ign    = (r_caller == r_ign);
    assign cur = r_idx[W-1:0];
    assign o_stat = '{
        scan_last: (r_idx == (W+1)'(N - 1)),
        is_table:  (!is_route && !r_flags[3] && !r_flags[4] && !is_ign)
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ign <= muta_pkg::IgnoredReset;
        else if (i_cfg_we) r_ign <= i_cfg_wdata;
    end

    // entry update values
    logic [W-1:0] e;
    logic         found;
    logic [31:0]  a_l, v_l, a_t, v_t;
    logic [7:0]   c;
    logic         fresh;
    always_comb begin
        found = r_hit || r_free_ok;
        e = r_hit ? r_hit_idx : r_free_idx;
        fresh = !r_hit;
        a_l = fresh ? 32'd0 : r_alast[e];
        v_l = fresh ? 32'd0 : r_vlast[e];
        a_t = fresh ? 32'd0 : r_atot[e];
        v_t = fresh ? 32'd0 : r_vtot[e];
        c   = fresh ? 8'd0 : r_cnt[e];
        if (r_flags[0]) begin
            if (r_flags[1]) begin
                a_l = a_l - r_t;
                if ($signed(c) < 8'sd127) c = c + 8'd1;
            end
            if (r_flags[2]) begin
                v_l = v_l - r_t;
                if ($signed(c) < 8'sd127) c = c + 8'd1;
            end
        end else if (c != 8'd0 && !c[7]) begin
            if (r_flags[1]) begin
                a_l = a_l + r_t;
                if (c != 8'h80) c = c - 8'd1;
            end
            if (r_flags[2]) begin
                v_l = v_l + r_t;
                if (c != 8'h80) c = c - 8'd1;
            end
            if (c == 8'd0) begin
                a_t = a_t + a_l;
                a_l = '0;
                v_t = v_t + v_l;
                v_l = '0;
            end
        end
    end

    logic [2:0] want;
    always_comb begin
        want = '0;
        if (r_flags[6:5] == 2'b11) want[muta_pkg::DevBoth] = 1'b1;
        else if (r_flags[5]) want[muta_pkg::DevSpk] = 1'b1;
        else want[muta_pkg::DevOth] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on <= '0;
            r_mix <= '0;
            r_valid <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dlast[i] <= '0;
                r_dtot[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_flags <= i_event_flags;
                r_t <= i_time_ms;
                r_caller <= i_caller_id;
                r_idx <= '0;
                r_hit <= 1'b0;
                r_free_ok <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (!r_hit && r_valid[cur] && r_ecaller[cur] == r_caller) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= cur;
                end
                if (!r_free_ok && !r_valid[cur]) begin
                    r_free_ok <= 1'b1;
                    r_free_idx <= cur;
                end
                r_idx <= r_idx + (W+1)'(1);
            end
            if (i_cmd.update) begin
                r_status <= muta_pkg::ST_DONE;
                r_oa <= '0;
                r_ov <= '0;
                r_oc <= '0;
                if (is_route) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_on[i] != want[i]) begin
                            if (r_mix != 16'd0) begin
                                if (!want[i]) begin
                                    r_dtot[i] <= r_dtot[i] + r_dlast[i] + r_t;
                                    r_dlast[i] <= '0;
                                end else begin
                                    r_dlast[i] <= 32'd0 - r_t;
                                end
                            end
                            r_on[i] <= want[i];
                        end
                    end
                end else if (is_mstart) begin
                    if (r_mix == 16'd0) begin
                        for (int i = 0; i < 3; i++)
                            if (r_on[i]) r_dlast[i] <= r_dlast[i] - r_t;
                    end
                    if (r_mix != 16'hFFFF) r_mix <= r_mix + 16'd1;
                end else if (is_mstop) begin
                    if (r_mix == 16'd0) begin
                        r_status <= muta_pkg::ST_MIX_IGN;
                    end else begin
                        if (r_mix == 16'd1) begin
                            for (int i = 0; i < 3; i++) begin
                                if (r_on[i]) begin
                                    r_dtot[i] <= r_dtot[i] + r_dlast[i] + r_t;
                                    r_dlast[i] <= '0;
                                end
                            end
                        end
                        r_mix <= r_mix - 16'd1;
                    end
                end else if (is_ign) begin
                    r_status <= muta_pkg::ST_CALLER;
                end else if (!found) begin
                    r_status <= muta_pkg::ST_FULL;
                end else begin
                    r_valid[e] <= 1'b1;
                    r_ecaller[e] <= r_caller;
                    r_alast[e] <= a_l;
                    r_vlast[e] <= v_l;
                    r_atot[e] <= a_t;
                    r_vtot[e] <= v_t;
                    r_cnt[e] <= c;
                    r_oa <= a_t;
                    r_ov <= v_t;
                    r_oc <= c;
                    if (!r_flags[0]) begin
                        if (c == 8'd0 && (fresh || r_cnt[e] == 8'd0))
                            r_status <= muta_pkg::ST_ZERO;
                        else if (!fresh && r_cnt[e][7]) begin
                            r_status <= muta_pkg::ST_REMOVED;
                            r_valid[e] <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign o_status = r_status;
    assign o_caller_audio_total = r_oa;
    assign o_caller_video_total = r_ov;
    assign o_caller_refs = r_oc;
    assign o_speaker_total = r_dtot[muta_pkg::DevSpk];
    assign o_other_total = r_dtot[muta_pkg::DevOth];
    assign o_both_total = r_dtot[muta_pkg::DevBoth];
    assign o_mixer_refs = r_mix;
endmodule

// ===== sv/media_usage_time_accounting_core.sv =====
// Top level: media usage time accounting core.
// Route/mixer/ignored events skip the table scan; codec events scan every table
// entry first (one table entry compared per cycle) before the update and result.
// A new request is taken only while idle, not before the previous result is given.
// Result strobe o_valid is high for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears device totals, the mixer count and table valid bits.
module media_usage_time_accounting_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic [6:0]          i_event_flags,
    input  logic signed [31:0]  i_time_ms,
    input  logic [31:0]         i_caller_id,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_caller_audio_total,
    output logic signed [31:0]  o_caller_video_total,
    output logic signed [7:0]   o_caller_refs,
    output logic signed [31:0]  o_speaker_total,
    output logic signed [31:0]  o_other_total,
    output logic signed [31:0]  o_both_total,
    output logic [15:0]         o_mixer_refs
);
    muta_pkg::t_cmd  cmd;
    muta_pkg::t_stat stat;

    muta_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    muta_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_event_flags(i_event_flags), .i_time_ms(i_time_ms),
        .i_caller_id(i_caller_id), .o_status(o_status),
        .o_caller_audio_total(o_caller_audio_total),
        .o_caller_video_total(o_caller_video_total),
        .o_caller_refs(o_caller_refs), .o_speaker_total(o_speaker_total),
        .o_other_total(o_other_total), .o_both_total(o_both_total),
        .o_mixer_refs(o_mixer_refs)
    );

    assign o_valid = cmd.done;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside request");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> busy) else $error("load did not start work");
    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> o_valid) else $error("update without result");
endmodule

// ===== tb/sv/tb_media_usage_time_accounting_core.sv =====
// Testbench: random and directed usage events checked against an in-bench accounting predictor.
`timescale 1ns / 1ps
module tb_media_usage_time_accounting_core;
    typedef struct packed {
        logic [6:0]  flags;
        logic [31:0] tms;
        logic [31:0] caller;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] a_tot;
        logic [31:0] v_tot;
        logic [7:0]  refs;
        logic [31:0] spk;
        logic [31:0] oth;
        logic [31:0] both;
        logic [15:0] mix;
    } t_rsp;

    localparam int NEnt = muta_pkg::TableEntries;
    localparam logic [6:0] F_START = 7'h01;
    localparam logic [6:0] F_AUDIO = 7'h02;
    localparam logic [6:0] F_VIDEO = 7'h04;
    localparam logic [6:0] F_MIX_ON = 7'h08;
    localparam logic [6:0] F_MIX_OFF = 7'h10;
    localparam logic [6:0] F_SPK = 7'h20;
    localparam logic [6:0] F_OTH = 7'h40;
    localparam int WatchLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic [6:0]  i_event_flags = '0;
    logic signed [31:0] i_time_ms = '0;
    logic [31:0] i_caller_id = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic signed [31:0] o_caller_audio_total, o_caller_video_total;
    logic signed [7:0]  o_caller_refs;
    logic signed [31:0] o_speaker_total, o_other_total, o_both_total;
    logic [15:0] o_mixer_refs;

    media_usage_time_accounting_core u_top (.*);

    // predictor state
    logic [31:0] ign_id;
    logic [2:0]  dev_on;
    logic [31:0] dev_last [3];
    logic [31:0] dev_tot [3];
    logic [15:0] mix_cnt;
    logic        ent_v [NEnt];
    logic [31:0] ent_caller [NEnt];
    logic [31:0] ent_alast [NEnt], ent_vlast [NEnt];
    logic [31:0] ent_atot [NEnt], ent_vtot [NEnt];
    logic signed [7:0] ent_cnt [NEnt];

    t_req pending_reqs [$];
    t_rsp expected_usage [$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   gap = 0;
    logic [31:0] callers [8];

    function automatic t_rsp account_event(t_req r);
        t_rsp o;
        logic [2:0] want;
        int e;
        o = '0;
        e = -1;
        if (r.flags & (F_SPK | F_OTH)) begin
            want = '0;
            if ((r.flags & (F_SPK | F_OTH)) == (F_SPK | F_OTH))
                want[muta_pkg::DevBoth] = 1'b1;
            else if (r.flags & F_SPK) want[muta_pkg::DevSpk] = 1'b1;
            else want[muta_pkg::DevOth] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                if (dev_on[i] != want[i]) begin
                    if (mix_cnt > 0) begin
                        if (!want[i]) begin
                            dev_tot[i] += dev_last[i] + r.tms;
                            dev_last[i] = '0;
                        end else begin
                            dev_last[i] = 32'd0 - r.tms;
                        end
                    end
                    dev_on[i] = want[i];
                end
            end
        end else if (r.flags & F_MIX_ON) begin
            if (mix_cnt == 0)
                for (int i = 0; i < 3; i++) if (dev_on[i]) dev_last[i] -= r.tms;
            if (mix_cnt != 16'hFFFF) mix_cnt++;
        end else if (r.flags & F_MIX_OFF) begin
            if (mix_cnt == 0) begin
                o.status = muta_pkg::ST_MIX_IGN;
            end else begin
                if (mix_cnt == 1)
                    for (int i = 0; i < 3; i++) if (dev_on[i]) begin
                        dev_tot[i] += dev_last[i] + r.tms;
                        dev_last[i] = '0;
                    end
                mix_cnt--;
            end
        end else if (r.caller == ign_id) begin
            o.status = muta_pkg::ST_CALLER;
        end else begin
            for (int i = 0; i < NEnt; i++)
                if (e < 0 && ent_v[i] && ent_caller[i] == r.caller) e = i;
            if (e < 0) begin
                for (int i = 0; i < NEnt; i++) if (e < 0 && !ent_v[i]) e = i;
                if (e >= 0) begin
                    ent_v[e] = 1'b1;
                    ent_caller[e] = r.caller;
                    ent_alast[e] = '0; ent_vlast[e] = '0;
                    ent_atot[e] = '0; ent_vtot[e] = '0;
                    ent_cnt[e] = '0;
                end
            end
            if (e < 0) begin
                o.status = muta_pkg::ST_FULL;
            end else begin
                if (r.flags & F_START) begin
                    if (r.flags & F_AUDIO) begin
                        ent_alast[e] -= r.tms;
                        if (ent_cnt[e] < 127) ent_cnt[e]++;
                    end
                    if (r.flags & F_VIDEO) begin
                        ent_vlast[e] -= r.tms;
                        if (ent_cnt[e] < 127) ent_cnt[e]++;
                    end
                end else if (ent_cnt[e] == 0) begin
                    o.status = muta_pkg::ST_ZERO;
                end else if (ent_cnt[e] < 0) begin
                    o.status = muta_pkg::ST_REMOVED;
                    ent_v[e] = 1'b0;
                end else begin
                    if (r.flags & F_AUDIO) begin
                        ent_alast[e] += r.tms;
                        if (ent_cnt[e] > -128) ent_cnt[e]--;
                    end
                    if (r.flags & F_VIDEO) begin
                        ent_vlast[e] += r.tms;
                        if (ent_cnt[e] > -128) ent_cnt[e]--;
                    end
                    if (ent_cnt[e] == 0) begin
                        ent_atot[e] += ent_alast[e]; ent_alast[e] = '0;
                        ent_vtot[e] += ent_vlast[e]; ent_vlast[e] = '0;
                    end
                end
                o.a_tot = ent_atot[e];
                o.v_tot = ent_vtot[e];
                o.refs = ent_cnt[e];
            end
        end
        o.spk = dev_tot[muta_pkg::DevSpk];
        o.oth = dev_tot[muta_pkg::DevOth];
        o.both = dev_tot[muta_pkg::DevBoth];
        o.mix = mix_cnt;
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(logic [6:0] f, logic [31:0] t, logic [31:0] c);
        t_req r;
        r.flags = f; r.tms = t; r.caller = c;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_and_config(logic [31:0] val);
        while (pending_reqs.size() != 0 || expected_usage.size() != 0 || busy || start)
            @(posedge i_clk);
        repeat (NEnt + 8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        ign_id = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic rand_phase(int n);
        int k;
        logic [6:0] f;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                f = F_AUDIO | F_VIDEO | F_START;
                f = f & 7'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0) f = f & ~F_AUDIO & ~F_VIDEO;
                add_req(f, rand_time(),
                        ($urandom_range(0, 19) == 0) ? ign_id
                        : ($urandom_range(0, 9) == 0) ? $urandom()
                        : callers[$urandom_range(0, 7)]);
            end else if (k < 70) begin
                add_req(F_MIX_ON | 7'($urandom_range(0, 7)), rand_time(), $urandom());
            end else if (k < 82) begin
                add_req(F_MIX_OFF | 7'($urandom_range(0, 7)), rand_time(), $urandom());
            end else if (k < 95) begin
                f = 7'($urandom_range(1, 3)) << 5;
                add_req(f | 7'($urandom_range(0, 31)), rand_time(), $urandom());
            end else begin
                add_req(7'($urandom_range(0, 127)), $urandom(), $urandom());
            end
        end
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_usage.push_back(account_event(pending_reqs.pop_front()));
            gap = pick_gap();
            if (gap == 0 && pending_reqs.size() != 0) begin
                i_event_flags <= pending_reqs[0].flags;
                i_time_ms <= pending_reqs[0].tms;
                i_caller_id <= pending_reqs[0].caller;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap > 0) begin
                gap--;
            end else if (pending_reqs.size() != 0) begin
                start <= 1'b1;
                i_event_flags <= pending_reqs[0].flags;
                i_time_ms <= pending_reqs[0].tms;
                i_caller_id <= pending_reqs[0].caller;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp got, exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                got = {o_status, o_caller_audio_total, o_caller_video_total, o_caller_refs,
                       o_speaker_total, o_other_total, o_both_total, o_mixer_refs};
                if (expected_usage.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_usage.pop_front();
                    if (got.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                        errors++;
                    end
                    if (got.a_tot !== exp_r.a_tot) begin
                        $display("%0t: audio total exp %h got %h", $time, exp_r.a_tot, got.a_tot);
                        errors++;
                    end
                    if (got.v_tot !== exp_r.v_tot) begin
                        $display("%0t: video total exp %h got %h", $time, exp_r.v_tot, got.v_tot);
                        errors++;
                    end
                    if (got.refs !== exp_r.refs) begin
                        $display("%0t: refs exp %h got %h", $time, exp_r.refs, got.refs);
                        errors++;
                    end
                    if (got.spk !== exp_r.spk) begin
                        $display("%0t: speaker exp %h got %h", $time, exp_r.spk, got.spk);
                        errors++;
                    end
                    if (got.oth !== exp_r.oth) begin
                        $display("%0t: other exp %h got %h", $time, exp_r.oth, got.oth);
                        errors++;
                    end
                    if (got.both !== exp_r.both) begin
                        $display("%0t: both exp %h got %h", $time, exp_r.both, got.both);
                        errors++;
                    end
                    if (got.mix !== exp_r.mix) begin
                        $display("%0t: mixer exp %h got %h", $time, exp_r.mix, got.mix);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= WatchLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        ign_id = muta_pkg::IgnoredReset;
        dev_on = '0;
        mix_cnt = '0;
        for (int i = 0; i < 3; i++) begin
            dev_last[i] = '0; dev_tot[i] = '0;
        end
        for (int i = 0; i < NEnt; i++) ent_v[i] = 1'b0;
        for (int i = 0; i < 8; i++) callers[i] = $urandom();
        callers[0] = 32'h0; callers[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        add_req(F_MIX_OFF, 32'd5, 32'd0);
        add_req(F_SPK, 32'd10, 32'd0);
        add_req(F_MIX_ON, 32'h7FFF_FFFF, 32'd0);
        add_req(F_OTH, 32'h8000_0000, 32'd0);
        add_req(F_SPK | F_OTH, 32'hFFFF_FFFF, 32'd0);
        add_req(F_MIX_ON, 32'd100, 32'd0);
        add_req(F_MIX_OFF, 32'd200, 32'd0);
        add_req(F_MIX_OFF, 32'd300, 32'd0);
        add_req(F_START | F_AUDIO | F_VIDEO, 32'd50, muta_pkg::IgnoredReset);
        add_req(F_START | F_AUDIO | F_VIDEO, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(F_AUDIO, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(F_VIDEO, 32'd7, 32'hFFFF_FFFF);
        add_req(F_AUDIO, 32'd9, 32'hFFFF_FFFF);
        add_req(F_VIDEO, 32'd9, 32'hFFFF_FFFF);
        add_req(F_START, 32'd1, 32'd0);
        add_req(F_AUDIO, 32'd1, 32'd0);
        // one start then a two-track stop drives the count negative
        add_req(F_START | F_AUDIO, 32'd4, 32'd77);
        add_req(F_AUDIO | F_VIDEO, 32'd6, 32'd77);
        add_req(F_AUDIO, 32'd8, 32'd77);
        for (int i = 1; i <= NEnt; i++)
            add_req(F_START | F_AUDIO, 32'(i), 32'(i + 100));
        add_req(F_START | F_AUDIO, 32'd3, 32'd5000);
        drain_and_config(32'd0);
        add_req(F_START | F_VIDEO, 32'd3, 32'd0);
        rand_phase(350);
        drain_and_config(32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) add_req(F_AUDIO | F_VIDEO, 32'd1, 32'(i + 101));
        rand_phase(350);
        drain_and_config(callers[$urandom_range(2, 7)]);
        rand_phase(400);
        while (pending_reqs.size() != 0 || start) @(posedge i_clk);
        while (expected_usage.size() != 0) @(posedge i_clk);
        repeat (NEnt + 8) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
